// ===== hw/rtl/dcgc_pkg.sv =====
// Shared types and constants of the dual countdown game clock.
`timescale 1ns / 1ps

package dcgc_pkg;

  localparam int TIME_W     = 23;
  localparam int HELD_W     = 20;
  localparam int RHELD_W    = 16;
  localparam int SEC_W      = 14;
  localparam int PER_W      = 16;
  localparam int STEP_W     = 20;
  localparam int MAXSTEP_W  = 22;
  localparam int ELAPSED_W  = 16;
  localparam int CFG_W      = 23;
  localparam int CFG_IDX_W  = 3;
  localparam int DIV_STEPS  = TIME_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
  localparam int QINC_W     = HELD_W + 1;
  localparam int MUL_W      = STEP_W + QINC_W;

  localparam logic [PER_W-1:0] MS_PER_SEC = PER_W'(1000);

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_MS     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP_MS = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TIME_MS = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MS   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS     = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_MS  = CFG_IDX_W'(5);

  localparam logic [STEP_W-1:0]    RST_STEP_MS     = STEP_W'(60000);
  localparam logic [MAXSTEP_W-1:0] RST_MAX_STEP_MS = MAXSTEP_W'(300000);
  localparam logic [TIME_W-1:0]    RST_MAX_TIME_MS = TIME_W'(5940000);
  localparam logic [PER_W-1:0]     RST_PERIOD_MS   = PER_W'(50);
  localparam logic [RHELD_W-1:0]   RST_HOLD_MS     = RHELD_W'(5000);
  localparam logic [TIME_W-1:0]    RST_DEFAULT_MS  = TIME_W'(1800000);

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_PAUSE = 2'd2,
    MODE_DONE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    JOB_CHOSEN,
    JOB_HELD,
    JOB_PRIOR,
    JOB_T1,
    JOB_T2
  } job_t;

  typedef enum logic [2:0] {
    ST_READY,
    ST_LAUNCH,
    ST_WAIT,
    ST_MUL,
    ST_COMMIT
  } seq_state_t;

  typedef struct packed {
    logic div_start;
    job_t job;
    logic mul_en;
    logic commit;
  } seq_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hw/rtl/dcgc_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module dcgc_divider import dcgc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [TIME_W-1:0] dividend,
  input  logic [PER_W-1:0]  divisor,
  output logic [TIME_W-1:0] quotient,
  output div_stat_t         stat
);

  logic [DIV_CNT_W-1:0] count;
  logic                 done;
  logic [TIME_W-1:0]    work;
  logic [PER_W-1:0]     rem;
  logic [PER_W-1:0]     dsr;
  logic [PER_W:0]       trial;
  logic [PER_W:0]       diff;
  logic                 ge;

  assign trial = {rem, work[TIME_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else if (start) begin
      count <= DIV_CNT_W'(DIV_STEPS);
      done  <= 1'b0;
    end else begin
      done <= (count == DIV_CNT_W'(1));
      if (count != '0) begin
        count <= count - DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (count != '0) begin
      work <= {work[TIME_W-2:0], ge};
      rem  <= ge ? diff[PER_W-1:0] : trial[PER_W-1:0];
    end
  end

  assign quotient  = work;
  assign stat.busy = (count != '0);
  assign stat.done = done;

endmodule

// ===== hw/rtl/dcgc_seq.sv =====
// Sequencer that runs the divisions, the step multiply and the commit of one poll.
`timescale 1ns / 1ps

module dcgc_seq import dcgc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  mode_t     cur_mode,
  input  logic      div_done,
  input  logic      out_free,
  output logic      in_ready,
  output seq_ctrl_t ctrl
);

  seq_state_t state, state_next;
  job_t       job, job_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_READY;
      job   <= JOB_CHOSEN;
    end else begin
      state <= state_next;
      job   <= job_next;
    end
  end

  always_comb begin
    state_next = state;
    job_next   = job;
    case (state)
      ST_READY: begin
        if (in_valid) begin
          case (cur_mode)
            MODE_IDLE: begin
              job_next   = JOB_CHOSEN;
              state_next = ST_LAUNCH;
            end
            MODE_RUN: begin
              job_next   = JOB_T1;
              state_next = ST_LAUNCH;
            end
            default: state_next = ST_COMMIT;
          endcase
        end
      end
      ST_LAUNCH: state_next = ST_WAIT;
      ST_WAIT: begin
        if (div_done) begin
          case (job)
            JOB_CHOSEN: begin
              job_next   = JOB_HELD;
              state_next = ST_LAUNCH;
            end
            JOB_HELD: begin
              job_next   = JOB_PRIOR;
              state_next = ST_LAUNCH;
            end
            JOB_PRIOR: state_next = ST_MUL;
            JOB_T1: begin
              job_next   = JOB_T2;
              state_next = ST_LAUNCH;
            end
            default: state_next = ST_COMMIT;
          endcase
        end
      end
      ST_MUL: state_next = ST_COMMIT;
      ST_COMMIT: begin
        if (out_free) begin
          state_next = ST_READY;
        end
      end
      default: state_next = ST_READY;
    endcase
  end

  always_comb begin
    in_ready       = (state == ST_READY);
    ctrl.div_start = (state == ST_LAUNCH);
    ctrl.job       = job;
    ctrl.mul_en    = (state == ST_MUL);
    ctrl.commit    = (state == ST_COMMIT) && out_free;
  end

endmodule

// ===== hw/rtl/dual_countdown_game_clock_unit.sv =====
// Top level of the dual countdown game clock: registers, game state and commit logic.
`timescale 1ns / 1ps

// Each input beat is one poll tick (button and switch levels plus the milliseconds since
// the last tick) and yields exactly one result beat with the clock state after that tick.
// One tick is handled at a time. Before the game has begun it runs the display and held
// time divisions and then the step multiply, in a running game the divisions of both
// players' times, and when paused or finished none. The single shared restoring divider
// serves the whole-second display values and button acceleration steps. A new tick is
// accepted while the previous result still waits at the output. The user must write
// configuration registers via cfg_write, cfg_index, cfg_data only while idle (unchecked).
module dual_countdown_game_clock_unit import dcgc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 plus_pressed,
  input  logic                 minus_pressed,
  input  logic                 reset_pressed,
  input  logic                 left_switch_on,
  input  logic                 right_switch_on,
  input  logic [ELAPSED_W-1:0] elapsed_ms,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           mode,
  output logic [TIME_W-1:0]    player_one_ms,
  output logic [TIME_W-1:0]    player_two_ms,
  output logic [TIME_W-1:0]    start_time_ms,
  output logic                 one_to_move,
  output logic                 one_is_white,
  output logic                 one_won,
  output logic                 refresh_left,
  output logic                 refresh_right,
  output logic                 restart
);

  // configuration
  logic [STEP_W-1:0]    step_ms;
  logic [MAXSTEP_W-1:0] max_step_ms;
  logic [TIME_W-1:0]    max_time_ms;
  logic [PER_W-1:0]     step_period_ms;
  logic [RHELD_W-1:0]   reset_hold_ms;
  logic [TIME_W-1:0]    default_time_ms;

  // latched poll
  logic                 plus_q, minus_q, rst_q, left_q, right_q;
  logic [ELAPSED_W-1:0] elapsed_q;

  // game state
  mode_t              clock_mode, clock_mode_next;
  logic [TIME_W-1:0]  chosen_time, chosen_time_next;
  logic [TIME_W-1:0]  time_one, time_one_next;
  logic [TIME_W-1:0]  time_two, time_two_next;
  logic               turn_one, turn_one_next;
  logic               white_one, white_one_next;
  logic               winner_one, winner_one_next;
  logic [HELD_W-1:0]  held_time, held_time_next;
  logic [HELD_W-1:0]  prior_held_time, prior_held_time_next;
  logic [RHELD_W-1:0] reset_held_time, reset_held_time_next;
  logic               reset_level_before, reset_level_before_next;
  logic [SEC_W-1:0]   shown_left, shown_left_next;
  logic [SEC_W-1:0]   shown_right, shown_right_next;
  logic               refresh_left_next, refresh_right_next, restart_next;

  // scratch results
  logic [SEC_W-1:0]  sec_a, sec_b;
  logic [HELD_W-1:0] q_held, q_prior;
  logic [MUL_W-1:0]  prod;

  seq_ctrl_t         ctrl;
  div_stat_t         div_stat;
  logic [TIME_W-1:0] div_dividend, div_quotient;
  logic [PER_W-1:0]  div_divisor;
  logic              out_free;

  logic [PER_W-1:0]   per;
  logic               any_switch;
  logic               turn_run;
  logic [TIME_W-1:0]  elapsed_ext;
  logic [TIME_W-1:0]  t1_run, t2_run;
  logic [HELD_W-1:0]  held_eff;
  logic [HELD_W:0]    held_sum;
  logic [RHELD_W:0]   rheld_sum;
  logic [RHELD_W-1:0] rheld_sat;
  logic [QINC_W-1:0]  q_inc;
  logic [MAXSTEP_W-1:0] step_amt;
  logic [TIME_W:0]    plus_sum, minus_diff;
  logic               apply_step;

  assign out_free = !out_valid || out_ready;

  dcgc_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cur_mode (clock_mode),
    .div_done (div_stat.done),
    .out_free (out_free),
    .in_ready (in_ready),
    .ctrl     (ctrl)
  );

  dcgc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      step_ms         <= RST_STEP_MS;
      max_step_ms     <= RST_MAX_STEP_MS;
      max_time_ms     <= RST_MAX_TIME_MS;
      step_period_ms  <= RST_PERIOD_MS;
      reset_hold_ms   <= RST_HOLD_MS;
      default_time_ms <= RST_DEFAULT_MS;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_STEP_MS:     step_ms         <= cfg_data[STEP_W-1:0];
        CFG_MAX_STEP_MS: max_step_ms     <= cfg_data[MAXSTEP_W-1:0];
        CFG_MAX_TIME_MS: max_time_ms     <= cfg_data[TIME_W-1:0];
        CFG_PERIOD_MS:   step_period_ms  <= cfg_data[PER_W-1:0];
        CFG_HOLD_MS:     reset_hold_ms   <= cfg_data[RHELD_W-1:0];
        CFG_DEFAULT_MS:  default_time_ms <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      plus_q    <= plus_pressed;
      minus_q   <= minus_pressed;
      rst_q     <= reset_pressed;
      left_q    <= left_switch_on;
      right_q   <= right_switch_on;
      elapsed_q <= elapsed_ms;
    end
  end

  // values ahead of the divisions
  assign per         = (step_period_ms == '0) ? PER_W'(1) : step_period_ms;
  assign any_switch  = left_q || right_q;
  assign turn_run    = any_switch ? !left_q : turn_one;
  assign elapsed_ext = {{(TIME_W-ELAPSED_W){1'b0}}, elapsed_q};
  assign t1_run = !turn_run ? time_one :
                  (time_one > elapsed_ext) ? time_one - elapsed_ext : '0;
  assign t2_run = turn_run ? time_two :
                  (time_two > elapsed_ext) ? time_two - elapsed_ext : '0;
  assign held_eff = any_switch ? '0 : held_time;

  always_comb begin
    div_divisor = MS_PER_SEC;
    case (ctrl.job)
      JOB_CHOSEN: div_dividend = chosen_time;
      JOB_HELD: begin
        div_dividend = {{(TIME_W-HELD_W){1'b0}}, held_eff};
        div_divisor  = per;
      end
      JOB_PRIOR: begin
        div_dividend = {{(TIME_W-HELD_W){1'b0}}, prior_held_time};
        div_divisor  = per;
      end
      JOB_T1:  div_dividend = t1_run;
      JOB_T2:  div_dividend = t2_run;
      default: div_dividend = chosen_time;
    endcase
  end

  always_ff @(posedge clk) begin
    if (div_stat.done) begin
      case (ctrl.job)
        JOB_CHOSEN, JOB_T1: sec_a   <= div_quotient[SEC_W-1:0];
        JOB_T2:             sec_b   <= div_quotient[SEC_W-1:0];
        JOB_HELD:           q_held  <= div_quotient[HELD_W-1:0];
        JOB_PRIOR:          q_prior <= div_quotient[HELD_W-1:0];
        default: ;
      endcase
    end
  end

  assign q_inc = {1'b0, q_held} + QINC_W'(1);

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= {{(MUL_W-STEP_W){1'b0}}, step_ms} * {{(MUL_W-QINC_W){1'b0}}, q_inc};
    end
  end

  assign step_amt = (prod > {{(MUL_W-MAXSTEP_W){1'b0}}, max_step_ms}) ?
                    max_step_ms : prod[MAXSTEP_W-1:0];
  assign plus_sum   = {1'b0, chosen_time} + {{(TIME_W+1-MAXSTEP_W){1'b0}}, step_amt};
  assign minus_diff = {1'b0, chosen_time} - {{(TIME_W+1-MAXSTEP_W){1'b0}}, step_amt};
  assign apply_step = (held_eff == '0) || (q_held > q_prior);
  assign held_sum   = {1'b0, held_eff} + {{(HELD_W+1-ELAPSED_W){1'b0}}, elapsed_q};
  assign rheld_sum  = {1'b0, reset_held_time} + {1'b0, elapsed_q};
  assign rheld_sat  = rheld_sum[RHELD_W] ? '1 : rheld_sum[RHELD_W-1:0];

  always_comb begin
    clock_mode_next         = clock_mode;
    chosen_time_next        = chosen_time;
    time_one_next           = time_one;
    time_two_next           = time_two;
    turn_one_next           = turn_one;
    white_one_next          = white_one;
    winner_one_next         = winner_one;
    held_time_next          = held_time;
    prior_held_time_next    = prior_held_time;
    reset_held_time_next    = reset_held_time;
    reset_level_before_next = rst_q;
    shown_left_next         = shown_left;
    shown_right_next        = shown_right;
    refresh_left_next       = 1'b0;
    refresh_right_next      = 1'b0;
    restart_next            = 1'b0;

    if (rst_q) begin
      if (!reset_level_before) begin
        reset_held_time_next = '0;
      end else begin
        reset_held_time_next = rheld_sat;
        restart_next         = (rheld_sat >= reset_hold_ms);
      end
    end

    if (restart_next) begin
      clock_mode_next         = MODE_IDLE;
      chosen_time_next        = default_time_ms;
      time_one_next           = '0;
      time_two_next           = '0;
      turn_one_next           = 1'b0;
      white_one_next          = 1'b0;
      winner_one_next         = 1'b0;
      held_time_next          = '0;
      prior_held_time_next    = '0;
      reset_held_time_next    = '0;
      reset_level_before_next = 1'b0;
      shown_left_next         = '0;
      shown_right_next        = '0;
    end else begin
      case (clock_mode)
        MODE_IDLE: begin
          refresh_left_next  = (sec_a != shown_left);
          refresh_right_next = (sec_a != shown_right);
          shown_left_next    = sec_a;
          shown_right_next   = sec_a;
          if (any_switch) begin
            turn_one_next   = left_q;
            white_one_next  = left_q;
            time_one_next   = chosen_time;
            time_two_next   = chosen_time;
            clock_mode_next = MODE_RUN;
          end
          held_time_next = held_eff;
          if (plus_q != minus_q) begin
            if (apply_step) begin
              if (plus_q) begin
                if (chosen_time <= max_time_ms) begin
                  chosen_time_next = (plus_sum > {1'b0, max_time_ms}) ?
                                     max_time_ms : plus_sum[TIME_W-1:0];
                end
              end else begin
                chosen_time_next = minus_diff[TIME_W] ? '0 : minus_diff[TIME_W-1:0];
              end
            end
            prior_held_time_next = held_eff;
            held_time_next       = held_sum[HELD_W] ? '1 : held_sum[HELD_W-1:0];
          end else if (!plus_q) begin
            held_time_next = '0;
          end
        end
        MODE_RUN: begin
          clock_mode_next    = any_switch ? MODE_RUN : MODE_PAUSE;
          turn_one_next      = turn_run;
          time_one_next      = t1_run;
          time_two_next      = t2_run;
          refresh_left_next  = (sec_a != shown_left);
          refresh_right_next = (sec_b != shown_right);
          shown_left_next    = sec_a;
          shown_right_next   = sec_b;
          if (t1_run == '0 || t2_run == '0) begin
            clock_mode_next = MODE_DONE;
            winner_one_next = (t1_run != '0);
          end
        end
        MODE_PAUSE: begin
          if (any_switch) begin
            clock_mode_next = MODE_RUN;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_mode         <= MODE_IDLE;
      chosen_time        <= RST_DEFAULT_MS;
      time_one           <= '0;
      time_two           <= '0;
      turn_one           <= 1'b0;
      white_one          <= 1'b0;
      winner_one         <= 1'b0;
      held_time          <= '0;
      prior_held_time    <= '0;
      reset_held_time    <= '0;
      reset_level_before <= 1'b0;
      shown_left         <= '0;
      shown_right        <= '0;
      refresh_left       <= 1'b0;
      refresh_right      <= 1'b0;
      restart            <= 1'b0;
    end else if (ctrl.commit) begin
      clock_mode         <= clock_mode_next;
      chosen_time        <= chosen_time_next;
      time_one           <= time_one_next;
      time_two           <= time_two_next;
      turn_one           <= turn_one_next;
      white_one          <= white_one_next;
      winner_one         <= winner_one_next;
      held_time          <= held_time_next;
      prior_held_time    <= prior_held_time_next;
      reset_held_time    <= reset_held_time_next;
      reset_level_before <= reset_level_before_next;
      shown_left         <= shown_left_next;
      shown_right        <= shown_right_next;
      refresh_left       <= refresh_left_next;
      refresh_right      <= refresh_right_next;
      restart            <= restart_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // state only moves at a commit, which waits for a free output slot
  assign mode          = clock_mode;
  assign player_one_ms = time_one;
  assign player_two_ms = time_two;
  assign start_time_ms = chosen_time;
  assign one_to_move   = turn_one;
  assign one_is_white  = white_one;
  assign one_won       = (clock_mode == MODE_DONE) && winner_one;

`ifndef SYNTHESIS
  a_commit_slot: assert property (@(posedge clk) disable iff (rst)
    ctrl.commit |-> (!out_valid || out_ready))
    else $error("commit while result beat is stalled");

  a_accept_div_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> !div_stat.busy)
    else $error("poll accepted while divider busy");

  a_done_has_zero: assert property (@(posedge clk) disable iff (rst)
    (clock_mode == MODE_DONE) |-> (time_one == '0 || time_two == '0))
    else $error("finished game with both clocks nonzero");

  a_restart_reloads: assert property (@(posedge clk) disable iff (rst)
    (out_valid && restart) |-> (clock_mode == MODE_IDLE && !refresh_left && !refresh_right))
    else $error("restart beat without reloaded state");
`endif

endmodule
